// ----- hdl/midi_note_pairing_macros.svh -----
`ifndef MIDI_NOTE_PAIRING_MACROS_SVH
`define MIDI_NOTE_PAIRING_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define MNP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("midi_note_pairing: check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define MNP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("midi_note_pairing: check failed");

`endif

// ----- hdl/mnp_pkg.sv -----
package mnp_pkg;

  localparam int unsigned TPQ_W     = 15;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned PARAM_W   = 24;
  localparam int unsigned TICK_W    = 32;
  localparam int unsigned KEY_W     = 8;
  localparam int unsigned VEL_W     = 8;
  localparam int unsigned RATE_W    = 56;
  localparam int unsigned TIME_W    = 64;
  localparam int unsigned DEN_W     = 35;
  localparam int unsigned US_W      = 20;
  localparam int unsigned RATE_FRAC = 48;
  localparam int unsigned DIV_STEPS = PARAM_W + RATE_FRAC;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [TPQ_W-1:0] TPQ_RESET     = 15'd96;
  localparam logic [US_W-1:0]  US_PER_SECOND = 20'd1000000;

  localparam logic [KIND_W-1:0] KIND_TEMPO = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NOTE  = 2'd1;

  localparam logic [VEL_W-1:0] VEL_RELEASE = 8'h00;
  localparam logic [VEL_W-1:0] VEL_STOP    = 8'hFF;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEN,
    S_DIV,
    S_RATE,
    S_MUL_LO,
    S_MUL_HI,
    S_TIME,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic latch;
    logic div_init;
    logic div_step;
    logic rate_load;
    logic mul_lo;
    logic mul_hi;
    logic time_load;
    logic emit;
    logic store;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] in_kind;
    logic              in_key_ok;
    logic              is_release;
    logic              pend_valid;
    logic              out_free;
    logic              div_last;
  } ctrl_sts_t;

endpackage

// ----- hdl/mnp_ram.sv -----
module mnp_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/mnp_datapath.sv -----
module mnp_datapath #(
  parameter int unsigned KEY_COUNT = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mnp_pkg::TPQ_W-1:0]   cfg_wdata_i,
  input  logic [mnp_pkg::KIND_W-1:0]  event_kind_i,
  input  logic [mnp_pkg::PARAM_W-1:0] event_param_i,
  input  logic [mnp_pkg::TICK_W-1:0]  event_tick_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [mnp_pkg::KEY_W-1:0]   tone_key_o,
  output logic [mnp_pkg::TIME_W-1:0]  tone_start_o,
  output logic [mnp_pkg::TIME_W-1:0]  tone_end_o,
  input  mnp_pkg::ctrl_cmd_t          cmd_i,
  output mnp_pkg::ctrl_sts_t          sts_o
);

  localparam int unsigned ADDR_W = $clog2(KEY_COUNT);
  localparam logic [mnp_pkg::KEY_W:0] KEY_LIM = (mnp_pkg::KEY_W+1)'(KEY_COUNT);

  logic [mnp_pkg::TPQ_W-1:0]     tpq_q;
  logic [mnp_pkg::PARAM_W-1:0]   param_q;
  logic [mnp_pkg::TICK_W-1:0]    tick_q;
  logic [mnp_pkg::RATE_W-1:0]    rate_q;
  logic [mnp_pkg::DEN_W-1:0]     den_q;
  logic [mnp_pkg::DEN_W-1:0]     rem_q;
  logic [mnp_pkg::DEN_W-1:0]     rem_d;
  logic [mnp_pkg::PARAM_W-1:0]   dvd_q;
  logic [mnp_pkg::RATE_W-1:0]    quot_q;
  logic                          qbit;
  logic [mnp_pkg::DIV_CNT_W-1:0] cnt_q;
  logic [mnp_pkg::TPQ_W-1:0]     tpq_eff;
  logic [mnp_pkg::DEN_W:0]       rem_sh;
  logic [mnp_pkg::TICK_W-1:0]    mul_b;
  logic [63:0]                   prod;
  logic [63:0]                   lo_q;
  logic [55:0]                   hi_q;
  logic [mnp_pkg::TIME_W:0]      sum;
  logic [mnp_pkg::TIME_W-1:0]    time_d;
  logic [mnp_pkg::TIME_W-1:0]    time_q;
  logic [KEY_COUNT-1:0]          valid_q;
  logic [mnp_pkg::TIME_W-1:0]    ram_rdata;
  logic                          out_valid_q;
  logic [mnp_pkg::KEY_W-1:0]     key_q;
  logic [mnp_pkg::TIME_W-1:0]    start_q;
  logic [mnp_pkg::TIME_W-1:0]    end_q;
  logic [ADDR_W-1:0]             key_idx;
  logic [mnp_pkg::VEL_W-1:0]     vel;

  assign key_idx = param_q[ADDR_W-1:0];
  assign vel     = param_q[15:8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpq_q <= mnp_pkg::TPQ_RESET;
    end else if (cfg_we_i) begin
      tpq_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      param_q <= event_param_i;
      tick_q  <= event_tick_i;
    end
  end

  // restoring long division of tempo * 2^48 by tpq * 10^6, one bit per cycle
  assign tpq_eff = (tpq_q == '0) ? mnp_pkg::TPQ_W'(1) : tpq_q;
  assign rem_sh  = {rem_q, dvd_q[mnp_pkg::PARAM_W-1]};

  always_comb begin
    if (rem_sh >= {1'b0, den_q}) begin
      rem_d = mnp_pkg::DEN_W'(rem_sh - {1'b0, den_q});
      qbit  = 1'b1;
    end else begin
      rem_d = rem_sh[mnp_pkg::DEN_W-1:0];
      qbit  = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      den_q  <= mnp_pkg::DEN_W'(tpq_eff * mnp_pkg::US_PER_SECOND);
      rem_q  <= '0;
      quot_q <= '0;
      dvd_q  <= param_q;
      cnt_q  <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= rem_d;
      quot_q <= {quot_q[mnp_pkg::RATE_W-2:0], qbit};
      dvd_q  <= {dvd_q[mnp_pkg::PARAM_W-2:0], 1'b0};
      cnt_q  <= cnt_q + mnp_pkg::DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= '0;
    end else if (cmd_i.rate_load) begin
      rate_q <= quot_q;
    end
  end

  // one 32x32 multiplier, low half of the rate first, then the high half
  assign mul_b = cmd_i.mul_hi ? {8'b0, rate_q[mnp_pkg::RATE_W-1:32]} : rate_q[31:0];
  assign prod  = {32'b0, tick_q} * {32'b0, mul_b};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_lo) begin
      lo_q <= prod;
    end
    if (cmd_i.mul_hi) begin
      hi_q <= prod[55:0];
    end
    if (cmd_i.time_load) begin
      time_q <= time_d;
    end
  end

  assign sum = {1'b0, hi_q[47:0], 16'b0} + {17'b0, lo_q[63:16]};

  always_comb begin
    if ((|hi_q[55:48]) || sum[mnp_pkg::TIME_W]) begin
      time_d = '1;
    end else begin
      time_d = sum[mnp_pkg::TIME_W-1:0];
    end
  end

  mnp_ram #(
    .WIDTH(mnp_pkg::TIME_W),
    .DEPTH(KEY_COUNT)
  ) u_pending (
    .clk_i  (clk_i),
    .we_i   (cmd_i.store),
    .waddr_i(key_idx),
    .wdata_i(time_q),
    .re_i   (cmd_i.mul_lo),
    .raddr_i(key_idx),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.store) begin
      valid_q[key_idx] <= 1'b1;
    end else if (cmd_i.emit) begin
      valid_q[key_idx] <= 1'b0;
    end
  end

  // output register, refilled in the cycle its contents transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      key_q   <= param_q[mnp_pkg::KEY_W-1:0];
      start_q <= ram_rdata;
      end_q   <= time_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign tone_key_o   = key_q;
  assign tone_start_o = start_q;
  assign tone_end_o   = end_q;

  assign sts_o.in_kind    = event_kind_i;
  assign sts_o.in_key_ok  = {1'b0, event_param_i[mnp_pkg::KEY_W-1:0]} < KEY_LIM;
  assign sts_o.is_release = (vel == mnp_pkg::VEL_RELEASE) || (vel == mnp_pkg::VEL_STOP);
  assign sts_o.pend_valid = valid_q[key_idx];
  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign sts_o.div_last   = cnt_q == mnp_pkg::DIV_CNT_W'(mnp_pkg::DIV_STEPS - 1);

endmodule

// ----- hdl/mnp_ctrl.sv -----
`include "midi_note_pairing_macros.svh"

module mnp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output mnp_pkg::ctrl_cmd_t cmd_o,
  input  mnp_pkg::ctrl_sts_t sts_i
);

  mnp_pkg::state_e state_q;
  mnp_pkg::state_e state_d;
  logic            accept;

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mnp_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      mnp_pkg::S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
        if (in_valid_i) begin
          if (sts_i.in_kind == mnp_pkg::KIND_TEMPO) begin
            state_d = mnp_pkg::S_DEN;
          end else if (sts_i.in_kind == mnp_pkg::KIND_NOTE && sts_i.in_key_ok) begin
            state_d = mnp_pkg::S_MUL_LO;
          end
        end
      end
      mnp_pkg::S_DEN: begin
        cmd_o.div_init = 1'b1;
        state_d        = mnp_pkg::S_DIV;
      end
      mnp_pkg::S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = mnp_pkg::S_RATE;
        end
      end
      mnp_pkg::S_RATE: begin
        cmd_o.rate_load = 1'b1;
        state_d         = mnp_pkg::S_IDLE;
      end
      mnp_pkg::S_MUL_LO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = mnp_pkg::S_MUL_HI;
      end
      mnp_pkg::S_MUL_HI: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = mnp_pkg::S_TIME;
      end
      mnp_pkg::S_TIME: begin
        cmd_o.time_load = 1'b1;
        state_d         = mnp_pkg::S_FINISH;
      end
      mnp_pkg::S_FINISH: begin
        if (!sts_i.is_release) begin
          cmd_o.store = 1'b1;
          state_d     = mnp_pkg::S_IDLE;
        end else if (!sts_i.pend_valid) begin
          state_d = mnp_pkg::S_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = mnp_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = mnp_pkg::S_IDLE;
      end
    endcase
  end

  `MNP_ASSERT_NEXT(a_tempo_starts_div, accept && sts_i.in_kind == mnp_pkg::KIND_TEMPO, state_q == mnp_pkg::S_DEN)
  `MNP_ASSERT_NEXT(a_div_ends_in_rate, state_q == mnp_pkg::S_DIV && sts_i.div_last, state_q == mnp_pkg::S_RATE)
  `MNP_ASSERT_IMP(a_emit_needs_slot, cmd_o.emit, sts_i.out_free && sts_i.pend_valid && sts_i.is_release)
  `MNP_ASSERT_IMP(a_store_is_press, cmd_o.store, !sts_i.is_release && !cmd_o.emit)

endmodule

// ----- hdl/midi_note_pairing.sv -----
// Pairs MIDI note presses with their releases. Decoded events enter one at a time over a
// valid/ready channel; a tempo event (kind 0) recomputes seconds-per-tick, a note event
// (kind 1) converts its tick to Q32.32 seconds and either records the press time for its
// key or, on velocity 0 or 255 of a pending key, returns one tone (key, start, end) on the
// output channel; other kinds and unpressed releases produce nothing. A tempo event goes
// through a setup step, bit-serial restoring division and a load of the new rate. A note
// event takes two passes through one 32x32 multiplier, a saturating add, a read of the
// pending-start RAM and, for a press, a write to it.
// Input ready drops while an event is being worked on; a finished tone sits in an output
// register, so a new event is taken while it waits, and a release only stalls when that
// register is still full. ticks_per_quarter (reset value 96, zero acts as one) is to be
// written through cfg_we_i/cfg_wdata_i only while idle, which the block does not enforce;
// a write while idle only affects later tempo events. No clearing pass follows reset:
// pending flags are flip-flops cleared at once.
module midi_note_pairing #(
  parameter int unsigned KEY_COUNT = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mnp_pkg::TPQ_W-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [mnp_pkg::KIND_W-1:0]  event_kind_i,
  input  logic [mnp_pkg::PARAM_W-1:0] event_param_i,
  input  logic [mnp_pkg::TICK_W-1:0]  event_tick_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [mnp_pkg::KEY_W-1:0]   tone_key_o,
  output logic [mnp_pkg::TIME_W-1:0]  tone_start_o,
  output logic [mnp_pkg::TIME_W-1:0]  tone_end_o
);

  mnp_pkg::ctrl_cmd_t cmd;
  mnp_pkg::ctrl_sts_t sts;

  mnp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  mnp_datapath #(
    .KEY_COUNT(KEY_COUNT)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .event_kind_i (event_kind_i),
    .event_param_i(event_param_i),
    .event_tick_i (event_tick_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .tone_key_o   (tone_key_o),
    .tone_start_o (tone_start_o),
    .tone_end_o   (tone_end_o),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

  localparam logic [mnp_pkg::KIND_W-1:0] KIND_OTHER = 2'd2;
  localparam logic [mnp_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int unsigned HALF_ITEMS   = 136;
  localparam int unsigned SETTLE_CYC   = 100;
  localparam int unsigned HOLD_CYC     = 400;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct packed {
    logic [mnp_pkg::KIND_W-1:0]  kind;
    logic [mnp_pkg::PARAM_W-1:0] param;
    logic [mnp_pkg::TICK_W-1:0]  tick;
  } midi_event_t;

  typedef struct packed {
    logic [mnp_pkg::KEY_W-1:0]  key;
    logic [mnp_pkg::TIME_W-1:0] t_on;
    logic [mnp_pkg::TIME_W-1:0] t_off;
  } tone_t;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         cfg_we_i    = 1'b0;
  logic [mnp_pkg::TPQ_W-1:0]    cfg_wdata_i = '0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_ready_o;
  logic [mnp_pkg::KIND_W-1:0]   event_kind_i;
  logic [mnp_pkg::PARAM_W-1:0]  event_param_i;
  logic [mnp_pkg::TICK_W-1:0]   event_tick_i;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic [mnp_pkg::KEY_W-1:0]    tone_key_o;
  logic [mnp_pkg::TIME_W-1:0]   tone_start_o;
  logic [mnp_pkg::TIME_W-1:0]   tone_end_o;

  midi_event_t         cur_ev = '0;

  assign event_kind_i  = cur_ev.kind;
  assign event_param_i = cur_ev.param;
  assign event_tick_i  = cur_ev.tick;

  midi_note_pairing dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .event_kind_i  (event_kind_i),
    .event_param_i (event_param_i),
    .event_tick_i  (event_tick_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .tone_key_o    (tone_key_o),
    .tone_start_o  (tone_start_o),
    .tone_end_o    (tone_end_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mirror of the block state
  logic [mnp_pkg::TPQ_W-1:0]  res_tpq = mnp_pkg::TPQ_RESET;
  logic [mnp_pkg::RATE_W-1:0] spt_rate = '0;
  logic [mnp_pkg::TIME_W-1:0] held_start [256];
  bit                         held_valid [256];

  midi_event_t event_q [$];
  tone_t       tone_q [$];

  int unsigned n_queued = 0;
  int unsigned n_taken  = 0;
  int unsigned n_tones  = 0;
  int unsigned n_err    = 0;
  int unsigned n_sat    = 0;
  int unsigned n_res    = 0;
  logic        idle_on  = 1'b1;
  logic        hold_req = 1'b0;
  logic        hold_ack = 1'b0;
  int unsigned tx_wait  = 0;
  int unsigned rx_wait  = 0;
  int unsigned hold_left = 0;
  logic [mnp_pkg::TICK_W-1:0] tick_now = '0;

  function automatic int unsigned gap_draw();
    return idle_on ? $urandom_range(0, 13) : 0;
  endfunction

  // Q8.48 seconds per tick, truncated
  function automatic logic [mnp_pkg::RATE_W-1:0] tempo_rate(
      logic [mnp_pkg::PARAM_W-1:0] tempo, logic [mnp_pkg::TPQ_W-1:0] tpq);
    logic [127:0] divisor;
    logic [127:0] dividend;
    divisor  = ((tpq == '0) ? 128'd1 : 128'(tpq)) * 128'(mnp_pkg::US_PER_SECOND);
    dividend = 128'(tempo) << mnp_pkg::RATE_FRAC;
    return mnp_pkg::RATE_W'(dividend / divisor);
  endfunction

  // Q32.32 seconds, saturating
  function automatic logic [mnp_pkg::TIME_W-1:0] tick_seconds(
      logic [mnp_pkg::TICK_W-1:0] tick, logic [mnp_pkg::RATE_W-1:0] rate);
    logic [127:0] scaled;
    scaled = (128'(tick) * 128'(rate)) >> 16;
    if (scaled[127:64] != '0) return '1;
    return scaled[63:0];
  endfunction

  function automatic void track_event(midi_event_t ev);
    logic [mnp_pkg::KEY_W-1:0]  key;
    logic [mnp_pkg::VEL_W-1:0]  vel;
    logic [mnp_pkg::TIME_W-1:0] t;
    tone_t                      done_tone;
    key = ev.param[mnp_pkg::KEY_W-1:0];
    vel = ev.param[mnp_pkg::KEY_W +: mnp_pkg::VEL_W];
    if (ev.kind == mnp_pkg::KIND_TEMPO) begin
      spt_rate = tempo_rate(ev.param, res_tpq);
      return;
    end
    if (ev.kind != mnp_pkg::KIND_NOTE) return;
    t = tick_seconds(ev.tick, spt_rate);
    if (t == '1) n_sat++;
    if (vel == mnp_pkg::VEL_RELEASE || vel == mnp_pkg::VEL_STOP) begin
      if (held_valid[key]) begin
        done_tone.key   = key;
        done_tone.t_on  = held_start[key];
        done_tone.t_off = t;
        tone_q.push_back(done_tone);
        held_valid[key] = 1'b0;
      end
    end else begin
      held_start[key] = t;
      held_valid[key] = 1'b1;
    end
  endfunction

  // event sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_wait    <= 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) begin
        track_event(cur_ev);
        n_taken <= n_taken + 1;
      end
      if (tx_wait != 0) begin
        tx_wait    <= tx_wait - 1;
        in_valid_i <= 1'b0;
      end else if (event_q.size() != 0) begin
        cur_ev     <= event_q.pop_front();
        in_valid_i <= 1'b1;
        tx_wait    <= gap_draw();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // tone receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    tone_t       want;
    int unsigned w;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_wait     <= 0;
      hold_left   <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (tone_q.size() == 0) begin
          n_err++;
          if (n_err <= MAX_REPORTS)
            $display("unexpected tone: key %0d start %h end %h",
                     tone_key_o, tone_start_o, tone_end_o);
        end else begin
          want = tone_q.pop_front();
          n_tones++;
          if (want.key != tone_key_o || want.t_on != tone_start_o ||
              want.t_off != tone_end_o) begin
            n_err++;
            if (n_err <= MAX_REPORTS)
              $display("tone mismatch: expected key %0d start %h end %h, %s",
                       want.key, want.t_on, want.t_off,
                       $sformatf("got key %0d start %h end %h",
                                 tone_key_o, tone_start_o, tone_end_o));
          end
        end
      end
      if (hold_left != 0) begin
        hold_left   <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else if (hold_ack != hold_req) begin
        // long back-pressure so the output register fills and input stalls
        hold_ack    <= hold_req;
        hold_left   <= HOLD_CYC;
        out_ready_i <= 1'b0;
      end else if (out_valid_o && out_ready_i) begin
        w = gap_draw();
        rx_wait     <= w;
        out_ready_i <= (w == 0);
      end else if (rx_wait != 0) begin
        rx_wait     <= rx_wait - 1;
        out_ready_i <= (rx_wait == 1);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic void add_event(logic [mnp_pkg::KIND_W-1:0] kind,
                                    logic [mnp_pkg::PARAM_W-1:0] param,
                                    logic [mnp_pkg::TICK_W-1:0] tick);
    midi_event_t ev;
    ev.kind  = kind;
    ev.param = param;
    ev.tick  = tick;
    event_q.push_back(ev);
    n_queued++;
  endfunction

  // upper parameter bits are don't-care for notes, so keep them random
  function automatic void add_note(logic [mnp_pkg::KEY_W-1:0] key,
                                   logic [mnp_pkg::VEL_W-1:0] vel,
                                   logic [mnp_pkg::TICK_W-1:0] tick);
    add_event(mnp_pkg::KIND_NOTE, {8'($urandom), vel, key}, tick);
  endfunction

  // every transfer taken, every tone back, then let a tempo division finish
  task automatic settle();
    while (n_taken != n_queued || tone_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic set_resolution(logic [mnp_pkg::TPQ_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    res_tpq = v;
    n_res++;
  endtask

  task automatic add_random(int unsigned n);
    logic [mnp_pkg::KEY_W-1:0] key_base;
    logic [mnp_pkg::KEY_W-1:0] key;
    int unsigned               pick;
    key_base = 8'($urandom);
    for (int unsigned i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 3) tick_now = $urandom;
      else tick_now = tick_now + $urandom_range(0, 2000);
      // a small key pool makes most releases find a pending press
      key = ($urandom_range(0, 99) < 15) ? 8'($urandom)
                                         : key_base + 8'($urandom_range(0, 7));
      if (pick < 5) begin
        if ($urandom_range(0, 9) < 7)
          add_event(mnp_pkg::KIND_TEMPO,
                    mnp_pkg::PARAM_W'($urandom_range(200000, 1200000)), tick_now);
        else
          add_event(mnp_pkg::KIND_TEMPO, mnp_pkg::PARAM_W'($urandom), tick_now);
      end else if (pick < 9) begin
        add_event(($urandom_range(0, 1) != 0) ? KIND_OTHER : KIND_SPARE,
                  mnp_pkg::PARAM_W'($urandom), $urandom);
      end else if (pick < 52) begin
        add_note(key, 8'($urandom_range(1, 254)), tick_now);
      end else begin
        add_note(key, ($urandom_range(0, 1) != 0) ? mnp_pkg::VEL_STOP : mnp_pkg::VEL_RELEASE,
                 tick_now);
      end
    end
  endtask

  initial begin : stimulus
    logic [mnp_pkg::TPQ_W-1:0] res_plan [7];
    res_plan[0] = 15'd1;
    res_plan[1] = 15'd32767;
    res_plan[2] = 15'd0;
    res_plan[3] = 15'd480;
    res_plan[4] = 15'($urandom_range(1, 32767));
    res_plan[5] = 15'($urandom_range(1, 1000));
    res_plan[6] = mnp_pkg::TPQ_RESET;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at the reset resolution, rate still zero at first
    add_note(8'd10, 8'd64, 32'd50);
    add_note(8'd10, mnp_pkg::VEL_RELEASE, 32'd80);
    add_note(8'd11, mnp_pkg::VEL_RELEASE, 32'd90);
    add_note(8'd12, mnp_pkg::VEL_STOP, 32'd95);
    add_event(KIND_OTHER, 24'hFFFFFF, 32'hFFFF_FFFF);
    add_event(KIND_SPARE, 24'h000000, 32'h0);
    add_event(mnp_pkg::KIND_TEMPO, 24'd500000, 32'h0);
    add_note(8'd0, 8'd1, 32'd0);
    add_note(8'd255, 8'd254, 32'd96);
    add_note(8'd0, 8'd127, 32'd200);
    add_note(8'd0, mnp_pkg::VEL_STOP, 32'd300);
    add_note(8'd255, mnp_pkg::VEL_RELEASE, 32'hFFFF_FFFF);
    add_note(8'd255, mnp_pkg::VEL_RELEASE, 32'hFFFF_FFFF);
    add_event(mnp_pkg::KIND_TEMPO, 24'hFFFFFF, 32'd7);
    add_note(8'd128, 8'h80, 32'hFFFF_FFFF);
    add_note(8'd128, mnp_pkg::VEL_RELEASE, 32'hFFFF_FFFF);
    add_event(mnp_pkg::KIND_TEMPO, 24'd0, 32'd9);
    add_note(8'd1, 8'd100, 32'd1000);
    add_note(8'd1, mnp_pkg::VEL_STOP, 32'd2000);
    add_event(mnp_pkg::KIND_TEMPO, 24'd1, 32'd11);
    add_note(8'd2, 8'd42, 32'd12345);
    add_note(8'd2, mnp_pkg::VEL_RELEASE, 32'h8000_0000);
    settle();

    for (int p = 0; p < 7; p++) begin
      set_resolution(res_plan[p]);
      idle_on <= (p % 3 != 1);
      if (p == 1 || p == 4) begin
        @(posedge clk_i);
        hold_req <= ~hold_req;
      end
      if (res_plan[p] <= 15'd1) begin
        // finest resolution with the slowest tempo overflows Q32.32
        add_event(mnp_pkg::KIND_TEMPO, 24'hFFFFFF, 32'd0);
        add_note(8'd7, 8'd90, 32'hFFFF_FFFF);
        add_note(8'd7, mnp_pkg::VEL_STOP, 32'hFFFF_FFFF);
        add_note(8'd8, 8'd90, 32'd0);
        add_note(8'd8, mnp_pkg::VEL_RELEASE, 32'h1000_0000);
      end
      add_random(HALF_ITEMS);
      settle();
      add_random(HALF_ITEMS);
      settle();
    end

    $display("%0d events taken over %0d resolution writes, %0d tones compared",
             n_taken, n_res, n_tones);
    $display("%0d predicted times saturated", n_sat);
    if (tone_q.size() != 0)
      $display("%0d tones never returned", tone_q.size());
    if (n_err == 0 && tone_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", n_err);
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(64'd10_000_000);
    $display("timeout with %0d of %0d events taken", n_taken, n_queued);
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/mnp_pkg.sv
hdl/mnp_ram.sv
hdl/mnp_datapath.sv
hdl/mnp_ctrl.sv
hdl/midi_note_pairing.sv
test/tb_top.sv
